[hw/rtl/fre_pkg.sv]
// ----------------------------------------------------------------------------
// fre_pkg
// Shared sizes and codes for the fragment reassembly engine.
// ----------------------------------------------------------------------------
package fre_pkg;

  localparam int MAX_MESSAGES   = 4;
  localparam int MAX_FRAGMENTS  = 8;
  localparam int MAX_FRAG_BYTES = 8;

  localparam int ENT_W   = (MAX_MESSAGES > 1) ? $clog2(MAX_MESSAGES) : 1;
  localparam int SEQ_W   = (MAX_FRAGMENTS > 1) ? $clog2(MAX_FRAGMENTS) : 1;
  localparam int BYTE_W  = (MAX_FRAG_BYTES > 1) ? $clog2(MAX_FRAG_BYTES) : 1;
  localparam int SLOTS   = MAX_MESSAGES * MAX_FRAGMENTS;
  localparam int MSG_BYTES = MAX_FRAGMENTS * MAX_FRAG_BYTES;
  localparam int STORE_DEPTH = MAX_MESSAGES * MSG_BYTES;
  localparam int ADDR_W  = ENT_W + SEQ_W + BYTE_W;
  localparam int SLOT_W  = ENT_W + SEQ_W;

  localparam logic [15:0] TIMEOUT_RST = 16'd2000;
  localparam logic [7:0]  HEADER_RST  = 8'd5;

  localparam logic       OP_FRAG  = 1'b0;
  localparam logic       OP_SWEEP = 1'b1;

  localparam logic       REG_TIMEOUT = 1'b0;
  localparam logic       REG_HEADER  = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PROC = 4'b0010,
    S_RD   = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

endpackage

[hw/rtl/fragment_reassembly_engine.sv]
// ----------------------------------------------------------------------------
// fragment_reassembly_engine
// Reassembles messages from fragment bytes into an in-order byte stream.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): a transaction is a fragment byte or a
//   timeout sweep tick. A transaction is taken in an idle cycle and processed
//   in the next one with in_stall high, so the input cannot take a new
//   transaction while the last one is processed.
//   When a byte completes a message, the stored bytes stream out on the result
//   channel (out_valid / out_stall) in fragment order, out_last on the final
//   byte. Each byte is a registered memory read (S_RD), then an output load
//   (S_EMIT), and each empty slot walked before the last byte is skipped in
//   S_RD. The input stays stalled until the last byte is loaded. A message of
//   only empty fragments emits nothing: it walks its slots and returns to idle.
//   If the receiver stalls, the output register holds its byte and the drain
//   waits; the final byte may wait while the next transaction is processed.
//   Reset (synchronous, rst_n low) empties the message table, clears the output
//   and loads timeout_ms = 2000 and header_bytes = 5. There is no clearing
//   pass: a per-slot byte mask, cleared when an entry opens, makes bytes that
//   never arrived read as zero. Configuration writes (cfg_we) take effect at
//   once and are meant for idle.
// ----------------------------------------------------------------------------
module fragment_reassembly_engine (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_now_ms,
  input  logic [15:0] in_msg_id,
  input  logic [3:0]  in_frag_count,
  input  logic [7:0]  in_fragment_seq,
  input  logic [3:0]  in_frag_len,
  input  logic [7:0]  in_frame_length,
  input  logic [2:0]  in_byte_index,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_msg_id,
  output logic [7:0]  out_byte,
  output logic        out_last
);
  import fre_pkg::*;

  state_t state_r;
  state_t state_nxt;

  logic [15:0] timeout_r;
  logic [7:0]  header_r;

  // latched transaction
  logic        op_r;
  logic [31:0] now_r;
  logic [15:0] id_r;
  logic [3:0]  total_r;
  logic [7:0]  seq_r;
  logic [3:0]  plen_r;
  logic [7:0]  flen_r;
  logic [2:0]  bidx_r;
  logic [7:0]  data_r;

  // message table
  logic [MAX_MESSAGES-1:0] ent_valid_r;
  logic [MAX_MESSAGES-1:0] ent_valid_nxt;
  logic [15:0]             ent_id_r   [MAX_MESSAGES];
  logic [3:0]              ent_total_r[MAX_MESSAGES];
  logic [3:0]              ent_rcv_r  [MAX_MESSAGES];
  logic [MAX_FRAGMENTS-1:0] ent_mask_r[MAX_MESSAGES];
  logic [31:0]             ent_time_r [MAX_MESSAGES];
  logic [3:0]              slot_len_r [SLOTS];
  logic [MAX_FRAG_BYTES-1:0] slot_wr_r [SLOTS];

  // payload memory
  logic [7:0]             store_mem [STORE_DEPTH];
  logic [7:0]             rd_data_r;
  logic                   rd_wr_r;
  logic                   rd_en_r;

  // drain pointers
  logic [ENT_W-1:0] dr_e_r;
  logic [3:0]       dr_s_r;
  logic [3:0]       dr_b_r;
  logic             last_pend_r;

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic [15:0] out_id_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r;

  // -------------------------------------------------------------- processing
  logic             hit;
  logic [ENT_W-1:0] hit_e;
  logic             has_free;
  logic [ENT_W-1:0] free_e;
  logic             frame_bad;
  logic             open_bad;
  logic [ENT_W-1:0] sel_e;
  logic [3:0]       sel_total;
  logic [MAX_FRAGMENTS-1:0] sel_mask;
  logic [3:0]       sel_rcv;
  logic             seq_bad;
  logic             frag_ok;
  logic             final_byte;
  logic [3:0]       rcv_nxt;
  logic             complete;
  logic [8:0]       need_len;
  logic [MAX_MESSAGES-1:0] expired;
  logic [ADDR_W-1:0] wr_addr;
  logic [SEQ_W-1:0]  seq_idx;
  logic              tbl_we;
  logic [3:0]        rcv_upd;
  logic [MAX_FRAGMENTS-1:0]  mask_upd;
  logic [MAX_FRAG_BYTES-1:0] byte_bit;
  logic [MAX_FRAG_BYTES-1:0] wr_mask_upd;

  always_comb begin
    hit      = 1'b0;
    hit_e    = '0;
    has_free = 1'b0;
    free_e   = '0;
    for (int e = MAX_MESSAGES - 1; e >= 0; e--) begin
      if (ent_valid_r[e] && ent_id_r[e] == id_r) begin
        hit   = 1'b1;
        hit_e = ENT_W'(e);
      end
      if (!ent_valid_r[e]) begin
        has_free = 1'b1;
        free_e   = ENT_W'(e);
      end
    end
    for (int e = 0; e < MAX_MESSAGES; e++) begin
      expired[e] = ent_valid_r[e] && ((now_r - ent_time_r[e]) > {16'd0, timeout_r});
    end
  end

  assign need_len  = {1'b0, header_r} + {5'd0, plen_r};
  assign frame_bad = ({1'b0, flen_r} < need_len) || (plen_r > 4'(MAX_FRAG_BYTES)) ||
                     ((plen_r != 4'd0) && ({1'b0, bidx_r} >= plen_r));
  assign open_bad  = (total_r == 4'd0) || (total_r > 4'(MAX_FRAGMENTS)) ||
                     ({4'd0, total_r} <= seq_r) || !has_free;
  assign sel_e     = hit ? hit_e : free_e;
  assign sel_total = hit ? ent_total_r[hit_e] : total_r;
  assign sel_mask  = hit ? ent_mask_r[hit_e] : '0;
  assign sel_rcv   = hit ? ent_rcv_r[hit_e] : 4'd0;
  assign seq_idx   = seq_r[SEQ_W-1:0];
  assign seq_bad   = (seq_r >= {4'd0, sel_total}) || (seq_r >= 8'(MAX_FRAGMENTS)) ||
                     sel_mask[seq_idx];
  assign frag_ok   = !frame_bad && (hit || !open_bad) && !seq_bad;
  assign final_byte = (plen_r == 4'd0) || ({1'b0, bidx_r} + 4'd1 == plen_r);
  assign rcv_nxt   = sel_rcv + 4'd1;
  assign complete  = final_byte && (rcv_nxt == sel_total);
  assign wr_addr   = {sel_e, seq_idx, bidx_r[BYTE_W-1:0]};

  assign tbl_we      = (state_r == S_PROC) && (op_r == OP_FRAG) && frag_ok;
  assign rcv_upd     = final_byte ? rcv_nxt : sel_rcv;
  assign mask_upd    = final_byte ? (sel_mask | (MAX_FRAGMENTS'(1) << seq_idx)) : sel_mask;
  assign byte_bit    = (plen_r != 4'd0) ? (MAX_FRAG_BYTES'(1) << bidx_r[BYTE_W-1:0]) : '0;
  assign wr_mask_upd = (hit ? slot_wr_r[{sel_e, seq_idx}] : '0) | byte_bit;

  // ------------------------------------------------------------------- drain
  logic [3:0]       cur_len;
  logic             later_bytes;
  logic [SLOT_W-1:0] cur_slot;
  logic [ADDR_W-1:0] rd_addr;
  logic             drain_done;
  logic             have_byte;
  logic             slot_end;
  logic             out_free;

  assign cur_slot   = {dr_e_r, dr_s_r[SEQ_W-1:0]};
  assign rd_addr    = {cur_slot, dr_b_r[BYTE_W-1:0]};
  assign cur_len    = slot_len_r[cur_slot];
  assign drain_done = ({1'b0, dr_s_r} >= {1'b0, ent_total_r[dr_e_r]}) ||
                      (dr_s_r >= 4'(MAX_FRAGMENTS));
  assign have_byte  = dr_b_r < cur_len;
  assign slot_end   = (dr_b_r + 4'd1 == cur_len);
  assign out_free   = !out_valid_r || !out_stall;

  always_comb begin
    later_bytes = 1'b0;
    for (int k = 0; k < MAX_FRAGMENTS; k++) begin
      if (4'(k) > dr_s_r && 4'(k) < ent_total_r[dr_e_r] &&
          slot_len_r[{dr_e_r, SEQ_W'(k)}] != 4'd0) begin
        later_bytes = 1'b1;
      end
    end
  end

  // ------------------------------------------------------------------ control
  always_comb begin
    state_nxt     = state_r;
    ent_valid_nxt = ent_valid_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PROC;
      end
      S_PROC: begin
        state_nxt = S_IDLE;
        if (op_r == OP_SWEEP) begin
          ent_valid_nxt = ent_valid_r & ~expired;
        end else if (frag_ok) begin
          // free the entry as soon as its last fragment is in
          ent_valid_nxt[sel_e] = !complete;
          if (complete) state_nxt = S_RD;
        end
      end
      S_RD: begin
        if (drain_done) state_nxt = S_IDLE;
        else if (have_byte) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_nxt = last_pend_r ? S_IDLE : S_RD;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = (state_r == S_EMIT && out_free) ? 1'b1 :
                         (out_stall ? out_valid_r : 1'b0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      timeout_r   <= TIMEOUT_RST;
      header_r    <= HEADER_RST;
      ent_valid_r <= '0;
      rd_en_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ent_valid_r <= ent_valid_nxt;
      rd_en_r     <= (state_r == S_RD) && !drain_done && have_byte;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_TIMEOUT: timeout_r <= cfg_wdata;
          REG_HEADER:  header_r  <= cfg_wdata[7:0];
          default: ;
        endcase
      end
    end
  end

  // message table update
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      if (!hit) begin
        ent_id_r[sel_e]    <= id_r;
        ent_total_r[sel_e] <= total_r;
      end
      ent_time_r[sel_e] <= now_r;
      ent_rcv_r[sel_e]  <= rcv_upd;
      ent_mask_r[sel_e] <= mask_upd;
      if (final_byte) slot_len_r[{sel_e, seq_idx}] <= plen_r;
      // opening an entry clears the byte masks of all its slots
      for (int k = 0; k < MAX_FRAGMENTS; k++) begin
        if (SEQ_W'(k) == seq_idx) begin
          slot_wr_r[{sel_e, SEQ_W'(k)}] <= wr_mask_upd;
        end else if (!hit) begin
          slot_wr_r[{sel_e, SEQ_W'(k)}] <= '0;
        end
      end
    end
  end

  // drain pointers
  always_ff @(posedge clk) begin
    if (tbl_we && complete) begin
      dr_e_r <= sel_e;
      dr_s_r <= 4'd0;
      dr_b_r <= 4'd0;
    end else if (state_r == S_RD && !drain_done) begin
      if (have_byte) begin
        last_pend_r <= slot_end && !later_bytes;
        if (slot_end) begin
          dr_s_r <= dr_s_r + 4'd1;
          dr_b_r <= 4'd0;
        end else begin
          dr_b_r <= dr_b_r + 4'd1;
        end
      end else begin
        // skip empty slot
        dr_s_r <= dr_s_r + 4'd1;
        dr_b_r <= 4'd0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      op_r    <= in_operation;
      now_r   <= in_now_ms;
      id_r    <= in_msg_id;
      total_r <= in_frag_count;
      seq_r   <= in_fragment_seq;
      plen_r  <= in_frag_len;
      flen_r  <= in_frame_length;
      bidx_r  <= in_byte_index;
      data_r  <= in_data_byte;
    end
    if (state_r == S_EMIT && out_free) begin
      out_id_r   <= ent_id_r[dr_e_r];
      out_byte_r <= rd_wr_r ? rd_data_r : 8'd0;
      out_last_r <= last_pend_r;
    end
  end

  // payload memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (tbl_we && plen_r != 4'd0) begin
      store_mem[wr_addr] <= data_r;
    end
    if (state_r == S_RD && !drain_done && have_byte) begin
      rd_data_r <= store_mem[rd_addr];
      rd_wr_r   <= slot_wr_r[cur_slot][dr_b_r[BYTE_W-1:0]];
    end
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_msg_id = out_id_r;
  assign out_byte   = out_byte_r;
  assign out_last   = out_last_r;

  // ---------------------------------------------------------------- checks
  a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> in_stall)
    else $error("input taken while busy");

  a_read_emit: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en_r |-> (state_r == S_EMIT))
    else $error("memory read not followed by emit");

  a_emit_load: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && out_free) |=> out_valid_r)
    else $error("emit did not load output");

  a_drain_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) |-> !ent_valid_r[dr_e_r])
    else $error("draining entry still open");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=>
      (out_valid_r && $stable(out_byte_r) && $stable(out_last_r) && $stable(out_id_r)))
    else $error("stalled result changed");

endmodule
